/* rtl/hkpp_pkg.sv */
`default_nettype none

package hkpp_pkg;

   localparam int BUFFER_DEPTH = 64;
   localparam int PHRASE_LEN   = 6;
   localparam int KEY_SLOTS    = PHRASE_LEN - 1;
   localparam int FILL_W       = $clog2(BUFFER_DEPTH + 1);
   localparam int SLOT_W       = $clog2(PHRASE_LEN);
   localparam int TYPE_W       = 2;
   localparam int KEY_W        = 8;
   localparam int POS_W        = 6;
   localparam int COUNT_W      = 7;

   // request kinds
   localparam logic [TYPE_W-1:0] REQ_APPEND   = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_DEDUP    = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_CLEAR    = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_RESERVED = 2'd3;

   // datapath operations
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd1;
   localparam logic [OP_W-1:0] OP_ACK    = 3'd2;
   localparam logic [OP_W-1:0] OP_REJECT = 3'd3;
   localparam logic [OP_W-1:0] OP_PAD    = 3'd4;
   localparam logic [OP_W-1:0] OP_KEY    = 3'd5;

   typedef struct packed {
      logic            load;
      logic [OP_W-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic is_clear;
      logic is_reserved;
      logic is_end;
      logic is_full;
      logic is_repeat;
      logic pad_end;
      logic pad_full;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic               write_valid;
      logic [POS_W-1:0]   position;
      logic [KEY_W-1:0]   value;
      logic               accepted;
      logic [COUNT_W-1:0] fill_count;
      logic               last;
   } rsp_beat_type;

endpackage

`default_nettype wire

/* rtl/hkpp_if.sv */
`default_nettype none

interface hkpp_req_if;
   logic                          valid;
   logic                          ready;
   logic [hkpp_pkg::TYPE_W-1:0]   req_type;
   logic [hkpp_pkg::KEY_W-1:0]    key_code;

   modport source (output valid, output req_type, output key_code, input ready);
   modport sink (input valid, input req_type, input key_code, output ready);
endinterface

interface hkpp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          write_valid;
   logic [hkpp_pkg::POS_W-1:0]    position;
   logic [hkpp_pkg::KEY_W-1:0]    value;
   logic                          accepted;
   logic [hkpp_pkg::COUNT_W-1:0]  fill_count;
   logic                          last;

   modport source (output valid, output write_valid, output position, output value,
                   output accepted, output fill_count, output last, input ready);
   modport sink (input valid, input write_valid, input position, input value,
                 input accepted, input fill_count, input last, output ready);
endinterface

`default_nettype wire

/* rtl/hkpp_datapath.sv */
`default_nettype none

module hkpp_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire hkpp_pkg::cmd_type           cmd,
   input  wire logic [hkpp_pkg::TYPE_W-1:0] req_type,
   input  wire logic [hkpp_pkg::KEY_W-1:0]  key_code,
   input  wire logic                        rsp_ready,
   output hkpp_pkg::status_type             status,
   output logic                             rsp_valid,
   output hkpp_pkg::rsp_beat_type           rsp_beat
);

   logic [hkpp_pkg::TYPE_W-1:0] req_type_ff;
   logic [hkpp_pkg::KEY_W-1:0]  key_ff;
   logic [hkpp_pkg::FILL_W-1:0] fill_level_ff, fill_level_in;
   logic [hkpp_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic [hkpp_pkg::KEY_W-1:0]  keys_ff [hkpp_pkg::KEY_SLOTS];
   logic [hkpp_pkg::KEY_W-1:0]  keys_in [hkpp_pkg::KEY_SLOTS];
   logic                        rsp_valid_ff, rsp_valid_in;
   hkpp_pkg::rsp_beat_type      beat_ff, beat_in;

   logic [hkpp_pkg::FILL_W-1:0] fill_inc;
   logic [hkpp_pkg::SLOT_W-1:0] slot_inc;
   logic                        hit;
   logic [hkpp_pkg::KEY_W-1:0]  write_data;

   assign fill_inc = fill_level_ff + 1'b1;
   assign slot_inc = (slot_ff == hkpp_pkg::SLOT_W'(hkpp_pkg::PHRASE_LEN - 1)) ?
                     '0 : slot_ff + 1'b1;

   always_comb begin
      hit = 1'b0;
      for (int s = 0; s < hkpp_pkg::KEY_SLOTS; s++) begin
         if ((hkpp_pkg::SLOT_W'(s) < slot_ff) && (keys_ff[s] == key_ff)) begin
            hit = 1'b1;
         end
      end
   end

   always_comb begin
      status.is_clear    = (req_type_ff == hkpp_pkg::REQ_CLEAR);
      status.is_reserved = (req_type_ff == hkpp_pkg::REQ_RESERVED);
      status.is_end      = (req_type_ff == hkpp_pkg::REQ_DEDUP) && (key_ff == '0);
      status.is_full     = (fill_level_ff == hkpp_pkg::FILL_W'(hkpp_pkg::BUFFER_DEPTH));
      status.is_repeat   = (req_type_ff == hkpp_pkg::REQ_DEDUP) && hit;
      status.pad_full    = (fill_inc == hkpp_pkg::FILL_W'(hkpp_pkg::BUFFER_DEPTH));
      status.pad_end     = (slot_inc == '0) || status.pad_full;
      status.out_free    = !rsp_valid_ff || rsp_ready;
   end

   assign write_data = (cmd.op == hkpp_pkg::OP_KEY) ? key_ff : '0;

   always_comb begin
      fill_level_in = fill_level_ff;
      slot_in       = slot_ff;
      keys_in       = keys_ff;
      beat_in       = beat_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      case (cmd.op)
         hkpp_pkg::OP_CLEAR: begin
            fill_level_in = '0;
            slot_in       = '0;
            for (int s = 0; s < hkpp_pkg::KEY_SLOTS; s++) begin
               keys_in[s] = '0;
            end
            beat_in      = '{write_valid: 1'b0, position: '0, value: '0,
                             accepted: 1'b1, fill_count: '0, last: 1'b1};
            rsp_valid_in = 1'b1;
         end
         hkpp_pkg::OP_ACK, hkpp_pkg::OP_REJECT: begin
            beat_in = '{write_valid: 1'b0,
                        position: hkpp_pkg::POS_W'(fill_level_ff),
                        value: '0,
                        accepted: (cmd.op == hkpp_pkg::OP_ACK),
                        fill_count: hkpp_pkg::COUNT_W'(fill_level_ff),
                        last: 1'b1};
            rsp_valid_in = 1'b1;
         end
         hkpp_pkg::OP_PAD, hkpp_pkg::OP_KEY: begin
            fill_level_in = fill_inc;
            slot_in       = slot_inc;
            for (int s = 0; s < hkpp_pkg::KEY_SLOTS; s++) begin
               if (hkpp_pkg::SLOT_W'(s) == slot_ff) begin
                  keys_in[s] = write_data;
               end
            end
            // the pad that hits the end of the buffer closes the item, key dropped
            beat_in = '{write_valid: 1'b1,
                        position: hkpp_pkg::POS_W'(fill_level_ff),
                        value: write_data,
                        accepted: (cmd.op == hkpp_pkg::OP_KEY) || !status.pad_full,
                        fill_count: hkpp_pkg::COUNT_W'(fill_inc),
                        last: (cmd.op == hkpp_pkg::OP_KEY) || status.pad_full};
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_level_ff <= '0;
         slot_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int s = 0; s < hkpp_pkg::KEY_SLOTS; s++) begin
            keys_ff[s] <= '0;
         end
      end else begin
         fill_level_ff <= fill_level_in;
         slot_ff       <= slot_in;
         rsp_valid_ff  <= rsp_valid_in;
         keys_ff       <= keys_in;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
      if (cmd.load) begin
         req_type_ff <= req_type;
         key_ff      <= key_code;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = beat_ff;

endmodule

`default_nettype wire

/* rtl/hkpp_ctrl.sv */
`default_nettype none

module hkpp_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire hkpp_pkg::status_type status,
   output logic                      req_ready,
   output hkpp_pkg::cmd_type         cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EVAL = 2'd1;
   localparam logic [1:0] ST_PAD  = 2'd2;
   localparam logic [1:0] ST_KEY  = 2'd3;

   logic [1:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.load = 1'b0;
      cmd.op   = hkpp_pkg::OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.is_clear) begin
               if (status.out_free) begin
                  cmd.op   = hkpp_pkg::OP_CLEAR;
                  state_in = ST_IDLE;
               end
            end else if (status.is_reserved) begin
               if (status.out_free) begin
                  cmd.op   = hkpp_pkg::OP_REJECT;
                  state_in = ST_IDLE;
               end
            end else if (status.is_end) begin
               if (status.out_free) begin
                  cmd.op   = hkpp_pkg::OP_ACK;
                  state_in = ST_IDLE;
               end
            end else if (status.is_full) begin
               if (status.out_free) begin
                  cmd.op   = hkpp_pkg::OP_REJECT;
                  state_in = ST_IDLE;
               end
            end else if (status.is_repeat) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_KEY;
            end
         end
         ST_PAD: begin
            if (status.out_free) begin
               cmd.op = hkpp_pkg::OP_PAD;
               if (status.pad_full) begin
                  state_in = ST_IDLE;
               end else if (status.pad_end) begin
                  state_in = ST_KEY;
               end
            end
         end
         ST_KEY: begin
            if (status.out_free) begin
               cmd.op   = hkpp_pkg::OP_KEY;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/hid_keycode_phrase_packer_unit.sv */
// non-write beats are issued in the eval state, write beats in the pad or key states
// one request at a time, input closed until the sequencer is idle; a repeated key walks
//   accept, eval, up to five pad beats, then a key beat unless the pads fill the buffer
// the shared output register sets the pace: a stalled result beat keeps the sequencer
//   from issuing its next beat until it leaves
// reset (synchronous, active high): fill level and phrase keys cleared, no beat pending
`default_nettype none

module hid_keycode_phrase_packer_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   hkpp_req_if.sink    req_link,
   hkpp_rsp_if.source  rsp_link
);

   // command and status between the sequencer and the datapath
   hkpp_pkg::cmd_type      cmd;
   hkpp_pkg::status_type   status;
   hkpp_pkg::rsp_beat_type rsp_beat;
   logic                   rsp_valid;
   logic                   req_ready;

   // sequencer: takes a request, picks the beat kind, walks the padding
   hkpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_link.valid),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   // datapath: fill level, phrase slot, key store, repeat compare, output register
   hkpp_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_type  (req_link.req_type),
      .key_code  (req_link.key_code),
      .rsp_ready (rsp_link.ready),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_beat  (rsp_beat)
   );

   // request side only opens while the sequencer is idle
   assign req_link.ready = req_ready;

   // result beat straight from the output register
   assign rsp_link.valid       = rsp_valid;
   assign rsp_link.write_valid = rsp_beat.write_valid;
   assign rsp_link.position    = rsp_beat.position;
   assign rsp_link.value       = rsp_beat.value;
   assign rsp_link.accepted    = rsp_beat.accepted;
   assign rsp_link.fill_count  = rsp_beat.fill_count;
   assign rsp_link.last        = rsp_beat.last;

`ifndef SYNTHESIS
   // a taken request keeps the input closed on the next cycle
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_link.valid && req_link.ready) |=> !req_link.ready)
      else $error("request side reopened right after accept");

   // a beat without a buffer write is always the only beat of its request
   a_nowrite_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_link.valid && !rsp_link.write_valid) |-> rsp_link.last)
      else $error("non-write beat not marked last");

   // a write advances the fill count by one past the written position
   a_write_position : assert property (@(posedge clock) disable iff (reset)
      (rsp_link.valid && rsp_link.write_valid) |->
      (hkpp_pkg::POS_W'(rsp_link.fill_count - 1'b1) == rsp_link.position))
      else $error("write position and fill count disagree");
`endif

endmodule

`default_nettype wire

/* test/tb_hid_keycode_phrase_packer_unit.sv */
`default_nettype none

module tb_hid_keycode_phrase_packer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   // cycles without any beat on either side before the run is called hung
   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 200;
   localparam int TAIL_CYCLES  = 16;

   // one row of the directed table: request plus an optional typed-in beat
   typedef struct {
      logic [hkpp_pkg::TYPE_W-1:0] kind;
      logic [hkpp_pkg::KEY_W-1:0]  key;
      bit                          typed;
      hkpp_pkg::rsp_beat_type      beat;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   hkpp_req_if req_link ();
   hkpp_rsp_if rsp_link ();

   hid_keycode_phrase_packer_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_link (req_link),
      .rsp_link (rsp_link)
   );

   always #5 clock = ~clock;

   // shadow of the packer: fill level and keys of the current phrase
   int                          shadow_fill;
   logic [hkpp_pkg::KEY_W-1:0]  shadow_phrase [hkpp_pkg::KEY_SLOTS];

   // buffer writes (and non-write beats) still owed by the block, oldest first
   hkpp_pkg::rsp_beat_type      buffer_writes_due [$];
   stim_row_type                directed_rows [$];

   int                          error_count = 0;
   int                          idle_cycles = 0;
   bit                          rsp_taken   = 1'b0;
   bit                          rsp_calm    = 1'b0;
   int                          rsp_stall   = 0;
   bit                          req_calm    = 1'b0;
   hkpp_pkg::rsp_beat_type      oldest_due;

   function automatic hkpp_pkg::rsp_beat_type make_beat(input int wv, input int pos,
                                                        input int val, input int acc,
                                                        input int fill, input int lst);
      hkpp_pkg::rsp_beat_type b;
      b.write_valid = wv[0];
      b.position    = pos[hkpp_pkg::POS_W-1:0];
      b.value       = val[hkpp_pkg::KEY_W-1:0];
      b.accepted    = acc[0];
      b.fill_count  = fill[hkpp_pkg::COUNT_W-1:0];
      b.last        = lst[0];
      return b;
   endfunction

   function automatic void reset_packer_state();
      shadow_fill = 0;
      foreach (shadow_phrase[s]) shadow_phrase[s] = '0;
   endfunction

   // one buffer write at the fill position, remembered if it lands in a key slot
   function automatic void store_byte(input logic [hkpp_pkg::KEY_W-1:0] val, input bit acc,
                                      input bit lst);
      int slot;
      int pos;
      slot = shadow_fill % hkpp_pkg::PHRASE_LEN;
      pos  = shadow_fill;
      if (slot < hkpp_pkg::KEY_SLOTS) shadow_phrase[slot] = val;
      shadow_fill++;
      buffer_writes_due.push_back(make_beat(1, pos, int'(val), int'(acc), shadow_fill,
                                            int'(lst)));
   endfunction

   // works out every beat that one request causes and queues them
   function automatic void pack_keycode(input logic [hkpp_pkg::TYPE_W-1:0] kind,
                                        input logic [hkpp_pkg::KEY_W-1:0] key);
      int  used;
      int  pad_end;
      bit  repeated;
      bit  final_pad;
      if (kind == hkpp_pkg::REQ_CLEAR) begin
         reset_packer_state();
         buffer_writes_due.push_back(make_beat(0, 0, 0, 1, 0, 1));
      end else if (kind == hkpp_pkg::REQ_RESERVED) begin
         buffer_writes_due.push_back(make_beat(0, shadow_fill, 0, 0, shadow_fill, 1));
      end else if (kind == hkpp_pkg::REQ_DEDUP && key == '0) begin
         // zero key ends the string, nothing written
         buffer_writes_due.push_back(make_beat(0, shadow_fill, 0, 1, shadow_fill, 1));
      end else if (shadow_fill >= hkpp_pkg::BUFFER_DEPTH) begin
         // full buffer drops the key
         buffer_writes_due.push_back(make_beat(0, shadow_fill, 0, 0, shadow_fill, 1));
      end else begin
         repeated = 1'b0;
         used     = shadow_fill % hkpp_pkg::PHRASE_LEN;
         if (kind == hkpp_pkg::REQ_DEDUP) begin
            for (int s = 0; s < used && s < hkpp_pkg::KEY_SLOTS; s++) begin
               if (shadow_phrase[s] == key) repeated = 1'b1;
            end
         end
         if (repeated) begin
            // pad out the phrase, stopping at the end of the buffer
            pad_end = shadow_fill - used + hkpp_pkg::PHRASE_LEN;
            if (pad_end > hkpp_pkg::BUFFER_DEPTH) pad_end = hkpp_pkg::BUFFER_DEPTH;
            while (shadow_fill < pad_end) begin
               final_pad = (shadow_fill + 1 == pad_end) &&
                           (pad_end >= hkpp_pkg::BUFFER_DEPTH);
               store_byte('0, !final_pad, final_pad);
            end
         end
         // no room left after padding means the key is lost
         if (shadow_fill < hkpp_pkg::BUFFER_DEPTH) store_byte(key, 1'b1, 1'b1);
      end
   endfunction

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t mismatch %s expected %0d actual %0d", $time, field, want, got);
         error_count++;
      end
   endtask

   // hold off the sender until every owed beat is back
   task automatic wait_drained();
      while (buffer_writes_due.size() != 0) @(posedge clock);
   endtask

   // drive one request beat after a random gap, then queue what it should cause
   task automatic send_request(input logic [hkpp_pkg::TYPE_W-1:0] kind,
                               input logic [hkpp_pkg::KEY_W-1:0] key,
                               input bit typed, input hkpp_pkg::rsp_beat_type typed_beat);
      int gap;
      if ($urandom_range(0, 19) == 0) req_calm = !req_calm;
      gap = req_calm ? 0 : int'($urandom_range(0, 16));
      repeat (gap) begin
         @(negedge clock);
         req_link.valid <= 1'b0;
      end
      @(negedge clock);
      req_link.valid    <= 1'b1;
      req_link.req_type <= kind;
      req_link.key_code <= key;
      @(posedge clock);
      while (!req_link.ready) @(posedge clock);
      pack_keycode(kind, key);
      // a typed-in row replaces the single predicted beat
      if (typed) begin
         void'(buffer_writes_due.pop_back());
         buffer_writes_due.push_back(typed_beat);
      end
      // the beat is taken, withdraw it so it is not taken again
      @(negedge clock);
      req_link.valid <= 1'b0;
   endtask

   // result side: every taken beat is checked against the oldest owed one
   always @(posedge clock) begin
      rsp_taken <= !reset && rsp_link.valid && rsp_link.ready;
      if (!reset && rsp_link.valid && rsp_link.ready) begin
         if (buffer_writes_due.size() == 0) begin
            $display("%0t mismatch expected no beat actual pos %0d value %0d", $time,
                     rsp_link.position, rsp_link.value);
            error_count++;
         end else begin
            oldest_due = buffer_writes_due.pop_front();
            check_field("write_valid", int'(oldest_due.write_valid),
                        int'(rsp_link.write_valid));
            check_field("position", int'(oldest_due.position), int'(rsp_link.position));
            check_field("value", int'(oldest_due.value), int'(rsp_link.value));
            check_field("accepted", int'(oldest_due.accepted), int'(rsp_link.accepted));
            check_field("fill_count", int'(oldest_due.fill_count),
                        int'(rsp_link.fill_count));
            check_field("last", int'(oldest_due.last), int'(rsp_link.last));
         end
      end
   end

   // receiver back-pressure: a fresh stall after each taken beat, calm stretches too
   always @(negedge clock) begin
      if (rsp_taken) begin
         if ($urandom_range(0, 23) == 0) rsp_calm = !rsp_calm;
         rsp_stall = rsp_calm ? 0 : int'($urandom_range(0, 16));
      end
      if (rsp_stall > 0) begin
         rsp_link.ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_link.ready <= 1'b1;
      end
   end

   // watchdog on cycles where no beat moves on either side
   always @(posedge clock) begin
      if ((req_link.valid && req_link.ready) || (rsp_link.valid && rsp_link.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[hid_keycode_phrase_packer_unit] ERROR");
            $finish;
         end
      end
   end

   initial begin
      int                          pick;
      logic [hkpp_pkg::TYPE_W-1:0] kind;
      logic [hkpp_pkg::KEY_W-1:0]  key;

      reset             = 1'b1;
      req_link.valid    = 1'b0;
      req_link.req_type = hkpp_pkg::REQ_APPEND;
      req_link.key_code = '0;
      rsp_link.ready    = 1'b0;
      reset_packer_state();

      // directed table, typed beats only where obvious
      directed_rows.push_back(stim_row_type'{hkpp_pkg::REQ_CLEAR, 8'h00, 1'b1,
                                             make_beat(0, 0, 0, 1, 0, 1)});
      directed_rows.push_back(stim_row_type'{hkpp_pkg::REQ_RESERVED, 8'hff, 1'b1,
                                             make_beat(0, 0, 0, 0, 0, 1)});
      directed_rows.push_back(stim_row_type'{hkpp_pkg::REQ_DEDUP, 8'h00, 1'b1,
                                             make_beat(0, 0, 0, 1, 0, 1)});
      directed_rows.push_back(stim_row_type'{hkpp_pkg::REQ_APPEND, 8'h04, 1'b1,
                                             make_beat(1, 0, 8'h04, 1, 1, 1)});
      directed_rows.push_back(stim_row_type'{hkpp_pkg::REQ_DEDUP, 8'h05, 1'b0, '0});
      // repeat inside the phrase pads to the next phrase
      directed_rows.push_back(stim_row_type'{hkpp_pkg::REQ_DEDUP, 8'h04, 1'b0, '0});
      directed_rows.push_back(stim_row_type'{hkpp_pkg::REQ_APPEND, 8'hff, 1'b0, '0});
      directed_rows.push_back(stim_row_type'{hkpp_pkg::REQ_APPEND, 8'h00, 1'b0, '0});
      directed_rows.push_back(stim_row_type'{hkpp_pkg::REQ_DEDUP, 8'hff, 1'b0, '0});
      directed_rows.push_back(stim_row_type'{hkpp_pkg::REQ_CLEAR, 8'h5a, 1'b1,
                                             make_beat(0, 0, 0, 1, 0, 1)});
      // same key again and again: one phrase per request until padding hits the end
      repeat (12) begin
         directed_rows.push_back(stim_row_type'{hkpp_pkg::REQ_DEDUP, 8'h10, 1'b0, '0});
      end
      // buffer full now, position wraps to zero
      directed_rows.push_back(stim_row_type'{hkpp_pkg::REQ_APPEND, 8'h20, 1'b1,
                                             make_beat(0, 0, 0, 0, 64, 1)});
      directed_rows.push_back(stim_row_type'{hkpp_pkg::REQ_DEDUP, 8'h00, 1'b1,
                                             make_beat(0, 0, 0, 1, 64, 1)});
      directed_rows.push_back(stim_row_type'{hkpp_pkg::REQ_RESERVED, 8'h00, 1'b1,
                                             make_beat(0, 0, 0, 0, 64, 1)});
      directed_rows.push_back(stim_row_type'{hkpp_pkg::REQ_CLEAR, 8'hff, 1'b1,
                                             make_beat(0, 0, 0, 1, 0, 1)});

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         send_request(directed_rows[r].kind, directed_rows[r].key,
                      directed_rows[r].typed, directed_rows[r].beat);
      end
      wait_drained();

      // random part: mostly appends and dedup appends from a small key pool
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = int'($urandom_range(0, 99));
         key  = hkpp_pkg::KEY_W'($urandom_range(0, 255));
         if (pick < 42) begin
            kind = hkpp_pkg::REQ_APPEND;
         end else if (pick < 84) begin
            kind = hkpp_pkg::REQ_DEDUP;
            if ($urandom_range(0, 3) != 0) key = hkpp_pkg::KEY_W'($urandom_range(1, 4));
         end else if (pick < 87) begin
            kind = hkpp_pkg::REQ_DEDUP;
            key  = '0;
         end else if (pick < 93) begin
            kind = hkpp_pkg::REQ_CLEAR;
         end else if (pick < 96) begin
            kind = hkpp_pkg::REQ_RESERVED;
         end else begin
            kind = hkpp_pkg::REQ_APPEND;
         end
         if ($urandom_range(0, 29) == 0) wait_drained();
         send_request(kind, key, 1'b0, '0);
      end
      @(negedge clock);
      req_link.valid <= 1'b0;

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[hid_keycode_phrase_packer_unit] OK");
      end else begin
         $display("[hid_keycode_phrase_packer_unit] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
